// ----- src/sum_checked_frame_receiver_assert.svh -----
// Assertion macros for the sum-checked frame receiver.
// Expects i_clk and i_rst_n in the scope of each use; define NO_ASSERTIONS to drop them.
`ifndef SUM_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SCFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scfr assertion failed");
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scfr assertion failed");
`else
`define SCFR_ASSERT_NOW(label, ante, cons)
`define SCFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/scfr_pkg.sv -----
// Shared types and constants for the sum-checked frame receiver.
// No dependencies.
package scfr_pkg;

    localparam logic [7:0]  SCFR_START0         = 8'h55;
    localparam logic [7:0]  SCFR_START1         = 8'hAA;
    localparam logic [7:0]  SCFR_CMD_STATUS     = 8'd5;
    localparam logic [15:0] SCFR_STATUS_MIN_LEN = 16'd18;
    localparam logic [15:0] SCFR_POS_BATTERY    = 16'd17;
    localparam logic [15:0] SCFR_POS_TAMPER     = 16'd9;
    localparam logic [15:0] SCFR_POS_REED       = 16'd4;

    typedef enum logic [7:0] {
        ST_START0  = 8'b0000_0001,
        ST_START1  = 8'b0000_0010,
        ST_VERSION = 8'b0000_0100,
        ST_CMD     = 8'b0000_1000,
        ST_LEN_HI  = 8'b0001_0000,
        ST_LEN_LO  = 8'b0010_0000,
        ST_DATA    = 8'b0100_0000,
        ST_CHK     = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [7:0]  frame_cmd;
        logic [15:0] frame_length;
        logic        status_updated;
        logic [7:0]  battery;
        logic [7:0]  tamper;
        logic [7:0]  reed;
    } t_result;

endpackage

// ----- src/scfr_parser.sv -----
// Frame parser: start bytes, header, payload count, sum check and status store.
// Depends on scfr_pkg.
module scfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output logic                o_res_valid,
    output scfr_pkg::t_result   o_res
);
    import scfr_pkg::*;

    t_state      r_state, n_state;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_cap4, n_cap4;
    logic [7:0]  r_cap9, n_cap9;
    logic [7:0]  r_cap17, n_cap17;
    logic [7:0]  r_battery, n_battery;
    logic [7:0]  r_tamper, n_tamper;
    logic [7:0]  r_reed, n_reed;

    logic [15:0] count_inc;
    logic [7:0]  sum_add;
    logic        upd;

    assign count_inc = r_count + 16'd1;
    assign sum_add   = r_sum + i_byte;

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_count     = r_count;
        n_cap4      = r_cap4;
        n_cap9      = r_cap9;
        n_cap17     = r_cap17;
        n_battery   = r_battery;
        n_tamper    = r_tamper;
        n_reed      = r_reed;
        o_res_valid = 1'b0;
        upd         = 1'b0;
        if (i_accept) begin
            case (r_state)
                ST_START0: begin
                    if (i_byte == SCFR_START0) begin
                        n_sum   = i_byte;
                        n_state = ST_START1;
                    end
                end
                ST_START1: begin
                    // a wrong second byte is not retried as a first start byte
                    if (i_byte == SCFR_START1) begin
                        n_sum   = sum_add;
                        n_state = ST_VERSION;
                    end else begin
                        n_state = ST_START0;
                    end
                end
                ST_VERSION: begin
                    n_sum   = sum_add;
                    n_state = ST_CMD;
                end
                ST_CMD: begin
                    n_sum   = sum_add;
                    n_cmd   = i_byte;
                    n_len   = 16'd0;
                    n_state = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    n_len   = {r_len[7:0], i_byte};
                    n_sum   = sum_add;
                    n_count = 16'd0;
                    n_state = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    n_len   = {r_len[7:0], i_byte};
                    n_sum   = sum_add;
                    n_count = 16'd0;
                    // empty payload: go straight to the checksum
                    n_state = ({r_len[7:0], i_byte} == 16'd0) ? ST_CHK : ST_DATA;
                end
                ST_DATA: begin
                    n_sum = sum_add;
                    if (r_count == SCFR_POS_REED)    n_cap4  = i_byte;
                    if (r_count == SCFR_POS_TAMPER)  n_cap9  = i_byte;
                    if (r_count == SCFR_POS_BATTERY) n_cap17 = i_byte;
                    n_count = count_inc;
                    if (count_inc == r_len) n_state = ST_CHK;
                end
                ST_CHK: begin
                    n_state = ST_START0;
                    if (r_sum == i_byte) begin
                        o_res_valid = 1'b1;
                        if (r_cmd == SCFR_CMD_STATUS && r_len >= SCFR_STATUS_MIN_LEN) begin
                            upd       = 1'b1;
                            n_battery = r_cap17;
                            n_tamper  = r_cap9;
                            n_reed    = r_cap4;
                        end
                    end
                end
                default: begin
                    n_state = ST_START0;
                end
            endcase
        end
    end

    always_comb begin
        o_res.frame_cmd      = r_cmd;
        o_res.frame_length   = r_len;
        o_res.status_updated = upd;
        o_res.battery        = n_battery;
        o_res.tamper         = n_tamper;
        o_res.reed           = n_reed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_START0;
            r_sum     <= 8'd0;
            r_cmd     <= 8'd0;
            r_len     <= 16'd0;
            r_count   <= 16'd0;
            r_cap4    <= 8'd0;
            r_cap9    <= 8'd0;
            r_cap17   <= 8'd0;
            r_battery <= 8'd0;
            r_tamper  <= 8'd0;
            r_reed    <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_count   <= n_count;
            r_cap4    <= n_cap4;
            r_cap9    <= n_cap9;
            r_cap17   <= n_cap17;
            r_battery <= n_battery;
            r_tamper  <= n_tamper;
            r_reed    <= n_reed;
        end
    end

endmodule

// ----- src/sum_checked_frame_receiver.sv -----
// Sum-checked frame receiver, top level.
// A result is registered in the output slot, or the skid slot when it is full.
// Throughput: one byte beat per cycle; a two-entry output/skid pair lets input
// continue while one result waits, and input stalls only when both are full.
// Reset (synchronous, active low) returns to hunting and clears stored status.
`include "sum_checked_frame_receiver_assert.svh"

module sum_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_frame_valid,
    input  logic        i_frame_ready,
    output logic [7:0]  o_frame_cmd,
    output logic [15:0] o_frame_length,
    output logic        o_status_updated,
    output logic [7:0]  o_battery,
    output logic [7:0]  o_tamper,
    output logic [7:0]  o_reed
);
    import scfr_pkg::*;

    logic    rx_fire;
    logic    res_valid;
    t_result res;
    logic    push;
    logic    pop;
    logic    out_free;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_rx_ready = !r_skid_valid;
    assign rx_fire    = i_rx_valid && o_rx_ready;

    scfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_fire),
        .i_byte      (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign push     = rx_fire && res_valid;
    assign pop      = r_out_valid && i_frame_ready;
    assign out_free = !r_out_valid || pop;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // advance the held result, park the new one behind it
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = push;
                n_skid       = res;
            end else begin
                n_out_valid = push;
                n_out       = res;
            end
        end else if (push) begin
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_frame_valid    = r_out_valid;
    assign o_frame_cmd      = r_out.frame_cmd;
    assign o_frame_length   = r_out.frame_length;
    assign o_status_updated = r_out.status_updated;
    assign o_battery        = r_out.battery;
    assign o_tamper         = r_out.tamper;
    assign o_reed           = r_out.reed;

    `SCFR_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `SCFR_ASSERT_NOW(a_update_only_status, o_frame_valid && o_status_updated,
        o_frame_cmd == SCFR_CMD_STATUS && o_frame_length >= SCFR_STATUS_MIN_LEN)
    `SCFR_ASSERT_NEXT(a_skid_drains, pop && !push && r_skid_valid,
        r_out_valid && !r_skid_valid)

endmodule
